### rtl/bitmap_slot_pool_unit_defines.svh
// Assertion macros for the bitmap slot pool.
`ifndef BITMAP_SLOT_POOL_UNIT_DEFINES_SVH
`define BITMAP_SLOT_POOL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap slot pool: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap slot pool: next-cycle check failed");

`endif

### rtl/bsp_pkg.sv
// Package: field widths, command and status codes of the bitmap slot pool.
package bsp_pkg;

   localparam int IDX_W    = 6;
   localparam int STATUS_W = 2;

   typedef enum logic [0:0] {
      CMD_PUT  = 1'b0,
      CMD_TAKE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

### rtl/bitmap_slot_pool_unit.sv
// Top level: slot pool with occupancy bitmap and slot value memory.
// A request passes the read stage register, then the response register, which drives
// rsp_valid. One request per cycle is accepted unless rsp_ready stalls the response;
// the store is a one-port-write, one-port-read memory with registered read data.
// Reset: all slots free, nothing occupied, response channel empty.
// Reset does not clear the slot memory; a slot is read only after a put wrote it.
`include "bitmap_slot_pool_unit_defines.svh"

module bitmap_slot_pool_unit
   import bsp_pkg::*;
#(
   parameter int SLOT_COUNT  = 64,
   parameter int VALUE_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [VALUE_WIDTH-1:0] req_item_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [IDX_W-1:0]       rsp_slot_index,
   output logic [VALUE_WIDTH-1:0] rsp_taken_value
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);

   logic [VALUE_WIDTH-1:0] mem [SLOT_COUNT];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   logic [SLOT_COUNT-1:0]  occ_ff;
   logic [SLOT_COUNT-1:0]  occ_in;

   logic                   pend_valid_ff;
   status_type             pend_status_ff;
   logic [SLOT_W-1:0]      pend_index_ff;
   logic                   pend_take_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [IDX_W-1:0]       rsp_index_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;

   logic                   accept;
   logic                   out_free;
   logic                   is_take;
   logic                   put_hit;
   logic                   take_hit;
   logic [SLOT_W-1:0]      put_pos;
   logic [SLOT_W-1:0]      take_pos;
   logic                   op_ok;
   logic [SLOT_W-1:0]      op_pos;
   status_type             op_status;

   // highest free and highest occupied slot
   always_comb begin
      put_hit  = ~&occ_ff;
      take_hit = |occ_ff;
      put_pos  = '0;
      take_pos = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!occ_ff[i]) put_pos = SLOT_W'(i);
         if (occ_ff[i])  take_pos = SLOT_W'(i);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_valid_ff || out_free;
   assign accept    = req_valid && req_ready;
   assign is_take   = (cmd_type'(req_cmd) == CMD_TAKE);

   always_comb begin
      if (is_take) begin
         op_ok     = take_hit;
         op_pos    = take_pos;
         op_status = take_hit ? ST_DONE : ST_EMPTY;
      end else begin
         op_ok     = put_hit;
         op_pos    = put_pos;
         op_status = put_hit ? ST_DONE : ST_FULL;
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (accept && op_ok) begin
         occ_in[op_pos] = !is_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // slot memory: write on put, registered read on take
   always_ff @(posedge clock) begin
      if (accept && op_ok && !is_take) begin
         mem[op_pos] <= req_item_value;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_take) begin
         rd_data_ff <= mem[take_pos];
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (req_ready) begin
         pend_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= op_status;
         pend_index_ff  <= op_ok ? op_pos : '0;
         pend_take_ff   <= op_ok && is_take;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && pend_valid_ff) begin
         rsp_status_ff <= pend_status_ff;
         rsp_index_ff  <= IDX_W'(pend_index_ff);
         rsp_value_ff  <= pend_take_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_index_ff;
   assign rsp_taken_value = rsp_value_ff;

   `BSP_ASSERT_NEXT(a_put_sets_slot, clock, reset, accept && !is_take && put_hit,
      occ_ff[$past(put_pos)])
   `BSP_ASSERT_NEXT(a_take_clears_slot, clock, reset, accept && is_take && take_hit,
      !occ_ff[$past(take_pos)])
   `BSP_ASSERT_NEXT(a_fail_keeps_map, clock, reset, accept && !op_ok,
      occ_ff == $past(occ_ff))
   `BSP_ASSERT_NOW(a_fail_index_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_DONE,
      rsp_index_ff == '0 && rsp_value_ff == '0)
   `BSP_ASSERT_NEXT(a_pend_drains, clock, reset, pend_valid_ff && out_free, rsp_valid_ff)

endmodule
